/* design/cpcr_pkg.sv */
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types and constants for the circle pair collision response
// Item, context and result structures, configuration registers, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcr_pkg;

  typedef enum logic [2:0] {
    CFG_SEP_GAIN_X     = 3'd0,
    CFG_SEP_GAIN_Y     = 3'd1,
    CFG_IMPULSE_GAIN_X = 3'd2,
    CFG_IMPULSE_GAIN_Y = 3'd3,
    CFG_FALL_DAMPING   = 3'd4,
    CFG_FLOOR_FRICTION = 3'd5,
    CFG_FLOOR_MARGIN   = 3'd6
  } cfg_idx_t;

  localparam logic [15:0] RST_SEP_GAIN_X     = 16'd6554;
  localparam logic [15:0] RST_SEP_GAIN_Y     = 16'd58982;
  localparam logic [15:0] RST_IMPULSE_GAIN_X = 16'd6554;
  localparam logic [15:0] RST_IMPULSE_GAIN_Y = 16'd32768;
  localparam logic [15:0] RST_FALL_DAMPING   = 16'd65208;
  localparam logic [15:0] RST_FLOOR_FRICTION = 16'd6554;
  localparam logic [15:0] RST_FLOOR_MARGIN   = 16'd66;

  typedef struct packed {
    logic [15:0] sep_gain_x;
    logic [15:0] sep_gain_y;
    logic [15:0] impulse_gain_x;
    logic [15:0] impulse_gain_y;
    logic [15:0] fall_damping;
    logic [15:0] floor_friction;
    logic [15:0] floor_margin;
  } cfg_t;

  typedef struct packed {
    logic signed [19:0] a_pos_x;
    logic signed [19:0] a_pos_y;
    logic signed [23:0] a_vel_x;
    logic signed [23:0] a_vel_y;
    logic        [16:0] a_radius;
    logic signed [19:0] b_pos_x;
    logic signed [19:0] b_pos_y;
    logic signed [23:0] b_vel_x;
    logic signed [23:0] b_vel_y;
    logic        [16:0] b_radius;
  } item_t;

  // front end: item plus centre offset and relative velocity
  typedef struct packed {
    item_t              itm;
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic signed [24:0] dvx;
    logic signed [24:0] dvy;
  } stg_t;

  // after the distance is known
  typedef struct packed {
    item_t              itm;
    logic signed [24:0] dvx;
    logic signed [24:0] dvy;
    logic signed [21:0] ovl;
  } ctx_t;

  typedef struct packed {
    logic signed [19:0] a_pos_x;
    logic signed [19:0] a_pos_y;
    logic signed [23:0] a_vel_x;
    logic signed [23:0] a_vel_y;
    logic signed [19:0] b_pos_x;
    logic signed [19:0] b_pos_y;
    logic signed [23:0] b_vel_x;
    logic signed [23:0] b_vel_y;
    logic               overlapped;
  } res_t;

  function automatic logic signed [19:0] sat_pos(input logic signed [25:0] v);
    logic signed [19:0] r;
    if ((&v[25:19]) || (~|v[25:19])) r = v[19:0];
    else if (v[25])                  r = {1'b1, 19'd0};
    else                             r = {1'b0, {19{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [23:0] sat_vel(input logic signed [31:0] v);
    logic signed [23:0] r;
    if ((&v[31:23]) || (~|v[31:23])) r = v[23:0];
    else if (v[31])                  r = {1'b1, 23'd0};
    else                             r = {1'b0, {23{1'b1}}};
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/circle_pair_collision_response_unit.sv */
// Throughput: one circle pair per cycle; every stage is a register slice and
// the whole pipeline advances while the output register is empty or taken.
// Depth is set by the 7-stage square root and the 9-stage quotient pipelines.
// Reset: rst_n synchronous active low clears valid bits and loads register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
// circle_pair_collision_response_unit: top level
// Stream in two circles, stream out both after separation and impulse.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pair_collision_response_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, zero pad
  input  wire logic [215:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
  // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
  output logic [175:0]      out_tdata,
  // overlapped
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int LAT   = 27;
  localparam int SQ_LN = 9;
  localparam int DV_LN = 10;

  logic               en;
  logic [LAT-1:0]     vld_r;
  cpcr_pkg::cfg_t     cfg_r;
  cpcr_pkg::item_t    in_itm;
  cpcr_pkg::stg_t     in_stg;
  cpcr_pkg::stg_t     stg_r [SQ_LN];
  cpcr_pkg::ctx_t     ctx_r [DV_LN];
  cpcr_pkg::ctx_t     ctx_nxt;
  logic [41:0]        sq_r;
  logic [20:0]        root_val;
  logic [20:0]        dist_f;
  logic [17:0]        rad_sum;
  logic [20:0]        adx, ady;
  logic [36:0]        numx_r, numy_r;
  logic [20:0]        den_r;
  logic               negx_r, negy_r;
  logic [16:0]        qx, qy;
  logic               nx, ny;
  cpcr_pkg::res_t     res;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  assign in_itm.a_pos_x  = in_tdata[19:0];
  assign in_itm.a_pos_y  = in_tdata[39:20];
  assign in_itm.a_vel_x  = in_tdata[63:40];
  assign in_itm.a_vel_y  = in_tdata[87:64];
  assign in_itm.a_radius = in_tdata[104:88];
  assign in_itm.b_pos_x  = in_tdata[124:105];
  assign in_itm.b_pos_y  = in_tdata[144:125];
  assign in_itm.b_vel_x  = in_tdata[168:145];
  assign in_itm.b_vel_y  = in_tdata[192:169];
  assign in_itm.b_radius = in_tdata[209:193];

  assign in_stg.itm = in_itm;
  assign in_stg.dx  = 21'(in_itm.b_pos_x) - 21'(in_itm.a_pos_x);
  assign in_stg.dy  = 21'(in_itm.b_pos_y) - 21'(in_itm.a_pos_y);
  assign in_stg.dvx = 25'(in_itm.a_vel_x) - 25'(in_itm.b_vel_x);
  assign in_stg.dvy = 25'(in_itm.a_vel_y) - 25'(in_itm.b_vel_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_gain_x     <= cpcr_pkg::RST_SEP_GAIN_X;
      cfg_r.sep_gain_y     <= cpcr_pkg::RST_SEP_GAIN_Y;
      cfg_r.impulse_gain_x <= cpcr_pkg::RST_IMPULSE_GAIN_X;
      cfg_r.impulse_gain_y <= cpcr_pkg::RST_IMPULSE_GAIN_Y;
      cfg_r.fall_damping   <= cpcr_pkg::RST_FALL_DAMPING;
      cfg_r.floor_friction <= cpcr_pkg::RST_FLOOR_FRICTION;
      cfg_r.floor_margin   <= cpcr_pkg::RST_FLOOR_MARGIN;
    end else if (cfg_we) begin
      case (cfg_index)
        cpcr_pkg::CFG_SEP_GAIN_X:     cfg_r.sep_gain_x     <= cfg_wdata;
        cpcr_pkg::CFG_SEP_GAIN_Y:     cfg_r.sep_gain_y     <= cfg_wdata;
        cpcr_pkg::CFG_IMPULSE_GAIN_X: cfg_r.impulse_gain_x <= cfg_wdata;
        cpcr_pkg::CFG_IMPULSE_GAIN_Y: cfg_r.impulse_gain_y <= cfg_wdata;
        cpcr_pkg::CFG_FALL_DAMPING:   cfg_r.fall_damping   <= cfg_wdata;
        cpcr_pkg::CFG_FLOOR_FRICTION: cfg_r.floor_friction <= cfg_wdata;
        cpcr_pkg::CFG_FLOOR_MARGIN:   cfg_r.floor_margin   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // distance of zero becomes one LSB
  assign dist_f  = (root_val == 21'd0) ? 21'd1 : root_val;
  assign rad_sum = {1'b0, stg_r[SQ_LN-1].itm.a_radius} + {1'b0, stg_r[SQ_LN-1].itm.b_radius};
  assign adx     = stg_r[SQ_LN-1].dx[20] ? 21'(-stg_r[SQ_LN-1].dx) : stg_r[SQ_LN-1].dx;
  assign ady     = stg_r[SQ_LN-1].dy[20] ? 21'(-stg_r[SQ_LN-1].dy) : stg_r[SQ_LN-1].dy;

  assign ctx_nxt.itm = stg_r[SQ_LN-1].itm;
  assign ctx_nxt.dvx = stg_r[SQ_LN-1].dvx;
  assign ctx_nxt.dvy = stg_r[SQ_LN-1].dvy;
  assign ctx_nxt.ovl = $signed({4'd0, rad_sum}) - $signed({1'b0, dist_f});

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= in_stg;
      for (int i = 1; i < SQ_LN; i++) stg_r[i] <= stg_r[i-1];
      sq_r <= 42'(stg_r[0].dx * stg_r[0].dx) + 42'(stg_r[0].dy * stg_r[0].dy);

      ctx_r[0] <= ctx_nxt;
      for (int i = 1; i < DV_LN; i++) ctx_r[i] <= ctx_r[i-1];
      numx_r <= {adx, 16'd0};
      numy_r <= {ady, 16'd0};
      den_r  <= dist_f;
      negx_r <= stg_r[SQ_LN-1].dx[20];
      negy_r <= stg_r[SQ_LN-1].dy[20];
    end
  end

  cpcr_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .sq_i   (sq_r),
    .dist_o (root_val)
  );

  cpcr_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num_i (numx_r),
    .den_i (den_r),
    .neg_i (negx_r),
    .q_o   (qx),
    .neg_o (nx)
  );

  cpcr_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num_i (numy_r),
    .den_i (den_r),
    .neg_i (negy_r),
    .q_o   (qy),
    .neg_o (ny)
  );

  cpcr_resp u_resp (
    .clk   (clk),
    .en    (en),
    .qx_i  (qx),
    .nx_i  (nx),
    .qy_i  (qy),
    .ny_i  (ny),
    .ctx_i (ctx_r[DV_LN-1]),
    .cfg_i (cfg_r),
    .res_o (res)
  );

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {res.b_vel_y, res.b_vel_x, res.b_pos_y, res.b_pos_x,
                       res.a_vel_y, res.a_vel_x, res.a_pos_y, res.a_pos_x};
  assign out_tuser  = res.overlapped;

endmodule

`default_nettype wire

/* design/cpcr_sqrt.sv */
// ----------------------------------------------------------------------------
// cpcr_sqrt: pipelined integer square root
// Bit-pair restoring square root of a 42-bit value, three steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [41:0] sq_i,
  output logic      [20:0] dist_o
);

  localparam int PER = 3;
  localparam int NST = 7;

  logic [41:0] n_r   [NST];
  logic [41:0] res_r [NST];
  logic [41:0] n_nxt [NST];
  logic [41:0] res_nxt [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    always_comb begin
      logic [41:0] n;
      logic [41:0] res;
      logic [41:0] bt;
      int          idx;
      if (k == 0) begin
        n   = sq_i;
        res = '0;
      end else begin
        n   = n_r[(k == 0) ? 0 : k - 1];
        res = res_r[(k == 0) ? 0 : k - 1];
      end
      for (int j = 0; j < PER; j++) begin
        idx = k * PER + j;
        bt  = 42'd1 << (40 - 2 * idx);
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
      end
      n_nxt[k]   = n;
      res_nxt[k] = res;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign dist_o = res_r[NST-1][20:0];

endmodule

`default_nettype wire

/* design/cpcr_div.sv */
// ----------------------------------------------------------------------------
// cpcr_div: pipelined restoring divider
// 37-bit magnitude over 21-bit divisor, 17 quotient bits, two per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [36:0] num_i,
  input  wire logic [20:0] den_i,
  input  wire logic        neg_i,
  output logic      [16:0] q_o,
  output logic             neg_o
);

  localparam int QB  = 17;
  localparam int PER = 2;
  localparam int NST = 9;

  logic [36:0] rem_r [NST];
  logic [16:0] q_r   [NST];
  logic [20:0] den_r [NST];
  logic        neg_r [NST];
  logic [36:0] rem_nxt [NST];
  logic [16:0] q_nxt   [NST];
  logic [20:0] den_nxt [NST];
  logic        neg_nxt [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    always_comb begin
      logic [36:0] rem;
      logic [16:0] q;
      logic [36:0] trial;
      int          s;
      if (k == 0) begin
        rem         = num_i;
        q           = '0;
        den_nxt[k]  = den_i;
        neg_nxt[k]  = neg_i;
      end else begin
        rem         = rem_r[(k == 0) ? 0 : k - 1];
        q           = q_r[(k == 0) ? 0 : k - 1];
        den_nxt[k]  = den_r[(k == 0) ? 0 : k - 1];
        neg_nxt[k]  = neg_r[(k == 0) ? 0 : k - 1];
      end
      for (int j = 0; j < PER; j++) begin
        s = k * PER + j;
        if (s < QB) begin
          trial = {16'd0, den_nxt[k]} << (QB - 1 - s);
          if (rem >= trial) begin
            rem = rem - trial;
            q   = q | (17'd1 << (QB - 1 - s));
          end
        end
      end
      rem_nxt[k] = rem;
      q_nxt[k]   = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        den_r[k] <= den_nxt[k];
        neg_r[k] <= neg_nxt[k];
      end
    end
  end

  assign q_o   = q_r[NST-1];
  assign neg_o = neg_r[NST-1];

endmodule

`default_nettype wire

/* design/cpcr_resp.sv */
// ----------------------------------------------------------------------------
// cpcr_resp: collision response pipeline
// Direction, relative velocity, correction and impulse, saturating update,
// fall damping and floor friction. Eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_resp (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [16:0]     qx_i,
  input  wire logic            nx_i,
  input  wire logic [16:0]     qy_i,
  input  wire logic            ny_i,
  input  wire cpcr_pkg::ctx_t  ctx_i,
  input  wire cpcr_pkg::cfg_t  cfg_i,
  output cpcr_pkg::res_t       res_o
);

  // R0
  logic signed [17:0] dirx0_r, diry0_r;
  cpcr_pkg::ctx_t     c0_r;
  // R1
  logic signed [42:0] px1_r, py1_r;
  logic signed [39:0] ox1_r, oy1_r;
  logic signed [17:0] dirx1_r, diry1_r;
  cpcr_pkg::ctx_t     c1_r;
  // R2
  logic signed [27:0] rel2_r;
  logic signed [56:0] cxp2_r, cyp2_r;
  logic signed [17:0] dirx2_r, diry2_r;
  cpcr_pkg::ctx_t     c2_r;
  // R3
  logic signed [45:0] ixp3_r, iyp3_r;
  logic signed [24:0] cx3_r, cy3_r;
  cpcr_pkg::ctx_t     c3_r;
  // R4
  logic signed [62:0] ixq4_r, iyq4_r;
  logic signed [24:0] cx4_r, cy4_r;
  cpcr_pkg::ctx_t     c4_r;
  // R5
  cpcr_pkg::res_t     r5_r;
  logic [16:0]        ar5_r;
  // R6
  cpcr_pkg::res_t     r6_r;
  logic signed [40:0] dmp6_r, frc6_r;
  logic               dflag6_r, fflag6_r;
  // R7
  cpcr_pkg::res_t     r7_r;

  logic signed [43:0] rel_sum;
  logic signed [30:0] ix5, iy5;
  logic               hit5;
  cpcr_pkg::res_t     r5_nxt;
  cpcr_pkg::res_t     r7_nxt;
  logic [17:0]        floor_lim;
  logic               fflag_nxt;

  assign rel_sum = 44'(px1_r) + 44'(py1_r);
  assign ix5     = ixq4_r[62:32];
  assign iy5     = iyq4_r[62:32];
  assign hit5    = (c4_r.ovl > 22'sd0);

  always_comb begin
    r5_nxt.overlapped = hit5;
    if (hit5) begin
      r5_nxt.a_pos_x = cpcr_pkg::sat_pos(26'(c4_r.itm.a_pos_x) - 26'(cx4_r));
      r5_nxt.a_pos_y = cpcr_pkg::sat_pos(26'(c4_r.itm.a_pos_y) - 26'(cy4_r));
      r5_nxt.b_pos_x = cpcr_pkg::sat_pos(26'(c4_r.itm.b_pos_x) + 26'(cx4_r));
      r5_nxt.b_pos_y = cpcr_pkg::sat_pos(26'(c4_r.itm.b_pos_y) + 26'(cy4_r));
      r5_nxt.a_vel_x = cpcr_pkg::sat_vel(32'(c4_r.itm.a_vel_x) - 32'(ix5));
      r5_nxt.a_vel_y = cpcr_pkg::sat_vel(32'(c4_r.itm.a_vel_y) - 32'(iy5));
      r5_nxt.b_vel_x = cpcr_pkg::sat_vel(32'(c4_r.itm.b_vel_x) + 32'(ix5));
      r5_nxt.b_vel_y = cpcr_pkg::sat_vel(32'(c4_r.itm.b_vel_y) + 32'(iy5));
    end else begin
      r5_nxt.a_pos_x = c4_r.itm.a_pos_x;
      r5_nxt.a_pos_y = c4_r.itm.a_pos_y;
      r5_nxt.b_pos_x = c4_r.itm.b_pos_x;
      r5_nxt.b_pos_y = c4_r.itm.b_pos_y;
      r5_nxt.a_vel_x = c4_r.itm.a_vel_x;
      r5_nxt.a_vel_y = c4_r.itm.a_vel_y;
      r5_nxt.b_vel_x = c4_r.itm.b_vel_x;
      r5_nxt.b_vel_y = c4_r.itm.b_vel_y;
    end
  end

  assign floor_lim = {1'b0, ar5_r} + {2'b00, cfg_i.floor_margin};
  assign fflag_nxt = ($signed(21'(r5_r.a_pos_y)) <= $signed({3'b000, floor_lim}));

  always_comb begin
    r7_nxt = r6_r;
    if (dflag6_r) r7_nxt.a_vel_y = dmp6_r[39:16];
    if (fflag6_r) r7_nxt.a_vel_x = frc6_r[39:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dirx0_r <= nx_i ? -$signed({1'b0, qx_i}) : $signed({1'b0, qx_i});
      diry0_r <= ny_i ? -$signed({1'b0, qy_i}) : $signed({1'b0, qy_i});
      c0_r    <= ctx_i;

      px1_r   <= c0_r.dvx * dirx0_r;
      py1_r   <= c0_r.dvy * diry0_r;
      ox1_r   <= dirx0_r * c0_r.ovl;
      oy1_r   <= diry0_r * c0_r.ovl;
      dirx1_r <= dirx0_r;
      diry1_r <= diry0_r;
      c1_r    <= c0_r;

      rel2_r  <= rel_sum[43:16];
      cxp2_r  <= ox1_r * $signed({1'b0, cfg_i.sep_gain_x});
      cyp2_r  <= oy1_r * $signed({1'b0, cfg_i.sep_gain_y});
      dirx2_r <= dirx1_r;
      diry2_r <= diry1_r;
      c2_r    <= c1_r;

      ixp3_r  <= dirx2_r * rel2_r;
      iyp3_r  <= diry2_r * rel2_r;
      cx3_r   <= cxp2_r[56:32];
      cy3_r   <= cyp2_r[56:32];
      c3_r    <= c2_r;

      ixq4_r  <= ixp3_r * $signed({1'b0, cfg_i.impulse_gain_x});
      iyq4_r  <= iyp3_r * $signed({1'b0, cfg_i.impulse_gain_y});
      cx4_r   <= cx3_r;
      cy4_r   <= cy3_r;
      c4_r    <= c3_r;

      r5_r    <= r5_nxt;
      ar5_r   <= c4_r.itm.a_radius;

      r6_r     <= r5_r;
      dmp6_r   <= r5_r.a_vel_y * $signed({1'b0, cfg_i.fall_damping});
      frc6_r   <= r5_r.a_vel_x * $signed({1'b0, cfg_i.floor_friction});
      // B below A after the push, A moving down
      dflag6_r <= r5_r.overlapped && r5_r.a_vel_y[23] && (r5_r.b_pos_y < r5_r.a_pos_y);
      fflag6_r <= fflag_nxt;

      r7_r <= r7_nxt;
    end
  end

  assign res_o = r7_r;

endmodule

`default_nettype wire

/* dv/circle_pair_collision_response_unit_tb.sv */
// ----------------------------------------------------------------------------
// circle_pair_collision_response_unit_tb: self-checking testbench
// Streams circle pairs through the unit under several register settings,
// predicts separation, impulse, damping and floor friction in fixed point,
// and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

class collision_scoreboard;
  longint          gain [7];
  cpcr_pkg::res_t  pending_q [$];
  int              n_err;

  function new();
    gain[cpcr_pkg::CFG_SEP_GAIN_X]     = cpcr_pkg::RST_SEP_GAIN_X;
    gain[cpcr_pkg::CFG_SEP_GAIN_Y]     = cpcr_pkg::RST_SEP_GAIN_Y;
    gain[cpcr_pkg::CFG_IMPULSE_GAIN_X] = cpcr_pkg::RST_IMPULSE_GAIN_X;
    gain[cpcr_pkg::CFG_IMPULSE_GAIN_Y] = cpcr_pkg::RST_IMPULSE_GAIN_Y;
    gain[cpcr_pkg::CFG_FALL_DAMPING]   = cpcr_pkg::RST_FALL_DAMPING;
    gain[cpcr_pkg::CFG_FLOOR_FRICTION] = cpcr_pkg::RST_FLOOR_FRICTION;
    gain[cpcr_pkg::CFG_FLOOR_MARGIN]   = cpcr_pkg::RST_FLOOR_MARGIN;
    n_err = 0;
  endfunction

  function void set_reg(cpcr_pkg::cfg_idx_t idx, logic [15:0] v);
    gain[idx] = v;
  endfunction

  static function longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  static function longint root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function void note_pair(cpcr_pkg::item_t it);
    longint ax, ay, avx, avy, ar, bx, by, bvx, bvy, br;
    longint dx, dy, cdist, ovl, dirx, diry, rel, cx, cy, ix, iy;
    longint unsigned sq;
    cpcr_pkg::res_t r;
    ax = it.a_pos_x; ay = it.a_pos_y; avx = it.a_vel_x; avy = it.a_vel_y;
    bx = it.b_pos_x; by = it.b_pos_y; bvx = it.b_vel_x; bvy = it.b_vel_y;
    ar = longint'({47'd0, it.a_radius});
    br = longint'({47'd0, it.b_radius});
    dx = bx - ax;
    dy = by - ay;
    sq = dx * dx + dy * dy;
    cdist = root(sq);
    if (cdist < 1) cdist = 1;  // epsilon on coincident centers
    ovl = ar + br - cdist;
    dirx = (dx * 65536) / cdist;
    diry = (dy * 65536) / cdist;
    rel = ((avy - bvy) * diry + (avx - bvx) * dirx) >>> 16;
    r.overlapped = ovl > 0;
    if (ovl > 0) begin
      cx = (dirx * ovl * gain[cpcr_pkg::CFG_SEP_GAIN_X]) >>> 32;
      cy = (diry * ovl * gain[cpcr_pkg::CFG_SEP_GAIN_Y]) >>> 32;
      ix = (dirx * rel * gain[cpcr_pkg::CFG_IMPULSE_GAIN_X]) >>> 32;
      iy = (diry * rel * gain[cpcr_pkg::CFG_IMPULSE_GAIN_Y]) >>> 32;
      ax = clip(ax - cx, 20); ay = clip(ay - cy, 20);
      bx = clip(bx + cx, 20); by = clip(by + cy, 20);
      avx = clip(avx - ix, 24); avy = clip(avy - iy, 24);
      bvx = clip(bvx + ix, 24); bvy = clip(bvy + iy, 24);
      if (avy < 0 && by < ay) avy = (avy * gain[cpcr_pkg::CFG_FALL_DAMPING]) >>> 16;
    end
    if (ay <= ar + gain[cpcr_pkg::CFG_FLOOR_MARGIN])
      avx = (avx * gain[cpcr_pkg::CFG_FLOOR_FRICTION]) >>> 16;
    r.a_pos_x = ax[19:0]; r.a_pos_y = ay[19:0];
    r.a_vel_x = avx[23:0]; r.a_vel_y = avy[23:0];
    r.b_pos_x = bx[19:0]; r.b_pos_y = by[19:0];
    r.b_vel_x = bvx[23:0]; r.b_vel_y = bvy[23:0];
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void check_result(cpcr_pkg::res_t got);
    cpcr_pkg::res_t want;
    longint e [9], a [9];
    string  nm [9];
    bit     bad;
    if (pending_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("unexpected result transaction: %p", got);
      return;
    end
    want = pending_q.pop_front();
    nm = '{"a_pos_x", "a_pos_y", "a_vel_x", "a_vel_y", "b_pos_x", "b_pos_y",
           "b_vel_x", "b_vel_y", "overlapped"};
    e = '{want.a_pos_x, want.a_pos_y, want.a_vel_x, want.a_vel_y, want.b_pos_x,
          want.b_pos_y, want.b_vel_x, want.b_vel_y, want.overlapped};
    a = '{got.a_pos_x, got.a_pos_y, got.a_vel_x, got.a_vel_y, got.b_pos_x,
          got.b_pos_y, got.b_vel_x, got.b_vel_y, got.overlapped};
    bad = 0;
    for (int k = 0; k < 9; k++) begin
      if (e[k] != a[k]) begin
        if (!bad) n_err++;
        bad = 1;
        if (n_err <= 10)
          $display("mismatch %s: expected %0d actual %0d", nm[k], e[k], a[k]);
      end
    end
  endfunction
endclass

module circle_pair_collision_response_unit_tb;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [175:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_wdata = '0;

  collision_scoreboard sb = new();
  bit burst = 0;
  int stall_cnt = 0;

  circle_pair_collision_response_unit dut (.*);

  always #4 clk = ~clk;

  // result side: check accepted transactions, random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result('{out_tdata[19:0], out_tdata[39:20], out_tdata[63:40],
                          out_tdata[87:64], out_tdata[107:88], out_tdata[127:108],
                          out_tdata[151:128], out_tdata[175:152], out_tuser[0]});
        stall_cnt = burst ? 0 : $urandom_range(0, 3);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pair(cpcr_pkg::item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.b_radius, it.b_vel_y, it.b_vel_x, it.b_pos_y, it.b_pos_x,
                  it.a_radius, it.a_vel_y, it.a_vel_x, it.a_pos_y, it.a_pos_x};
    do @(posedge clk); while (!in_tready);
    sb.note_pair(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] v [7]);
    for (int k = 0; k < 7; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cpcr_pkg::cfg_idx_t'(k);
      cfg_wdata <= v[k];
      @(posedge clk);
      sb.set_reg(cpcr_pkg::cfg_idx_t'(k), v[k]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cpcr_pkg::item_t rand_pair(int mode);
    cpcr_pkg::item_t it;
    logic [31:0] r;
    it.a_radius = 17'($urandom_range(0, 65536));
    it.b_radius = 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 9) == 0) it.a_radius = 17'($urandom);
    if ($urandom_range(0, 9) == 0) it.b_radius = 17'($urandom);
    if (mode == 0) begin
      // fully random fields
      it.a_pos_x = 20'($urandom); it.a_pos_y = 20'($urandom);
      it.b_pos_x = 20'($urandom); it.b_pos_y = 20'($urandom);
      it.a_vel_x = 24'($urandom); it.a_vel_y = 24'($urandom);
      it.b_vel_x = 24'($urandom); it.b_vel_y = 24'($urandom);
    end else begin
      // B placed near A so most pairs overlap
      it.a_pos_x = 20'($urandom_range(0, 524287) - 262144);
      it.a_pos_y = (mode == 2) ? 20'($urandom_range(0, 131072) - 8192)
                               : 20'($urandom_range(0, 524287) - 262144);
      r = $urandom_range(0, 2 * (it.a_radius + it.b_radius) + 2);
      it.b_pos_x = 20'(it.a_pos_x + r - (it.a_radius + it.b_radius + 1));
      r = $urandom_range(0, 2 * (it.a_radius + it.b_radius) + 2);
      it.b_pos_y = 20'(it.a_pos_y + r - (it.a_radius + it.b_radius + 1));
      if ($urandom_range(0, 1)) begin
        it.a_vel_x = 24'($urandom); it.a_vel_y = 24'($urandom);
        it.b_vel_x = 24'($urandom); it.b_vel_y = 24'($urandom);
      end else begin
        it.a_vel_x = 24'($urandom_range(0, 262143) - 131072);
        it.a_vel_y = 24'($urandom_range(0, 262143) - 131072);
        it.b_vel_x = 24'($urandom_range(0, 262143) - 131072);
        it.b_vel_y = 24'($urandom_range(0, 262143) - 131072);
      end
    end
    return it;
  endfunction

  initial begin
    cpcr_pkg::item_t it;
    logic [15:0] v [7];
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, coincident centers, extremes
    it = '0;
    send_pair(it);
    it.a_radius = 17'd65536; it.b_radius = 17'd65536;
    send_pair(it);
    it.a_vel_y = 24'h800000; it.b_vel_y = 24'h7fffff;
    send_pair(it);
    it = '{20'h7ffff, 20'h7ffff, 24'h7fffff, 24'h7fffff, 17'h1ffff,
           20'h80000, 20'h80000, 24'h800000, 24'h800000, 17'h1ffff};
    send_pair(it);
    it = '{20'h80000, 20'h80000, 24'h800000, 24'h800000, 17'h1ffff,
           20'h7ffff, 20'h7ffff, 24'h7fffff, 24'h7fffff, 17'h1ffff};
    send_pair(it);
    // B just below A, A falling; the impulse stops A, so fall damping stays off
    it = '{20'd200000, 20'd200000, 24'd100, -24'sd300000, 17'd65536,
           20'd200000, 20'd150000, -24'sd100, 24'd300000, 17'd65536};
    send_pair(it);
    // A resting on floor, no overlap
    it = '{20'd1000, 20'd65600, 24'd500000, 24'd0, 17'd65536,
           20'd400000, 20'd400000, 24'd0, 24'd0, 17'd100};
    send_pair(it);
    // touching exactly: overlap zero
    it = '{20'd0, 20'd300000, 24'd0, 24'd0, 17'd40000,
           20'd80000, 20'd300000, 24'd0, 24'd0, 17'd40000};
    send_pair(it);
    for (int k = 0; k < 8; k++) send_pair(rand_pair(k % 3));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 7; k++) begin
        case (ph)
          0: v[k] = 16'hffff;
          1: v[k] = 16'h0000;
          default: v[k] = 16'($urandom);
        endcase
      end
      if (ph == 4) begin
        v[cpcr_pkg::CFG_SEP_GAIN_X]     = cpcr_pkg::RST_SEP_GAIN_X;
        v[cpcr_pkg::CFG_SEP_GAIN_Y]     = cpcr_pkg::RST_SEP_GAIN_Y;
        v[cpcr_pkg::CFG_IMPULSE_GAIN_X] = cpcr_pkg::RST_IMPULSE_GAIN_X;
        v[cpcr_pkg::CFG_IMPULSE_GAIN_Y] = cpcr_pkg::RST_IMPULSE_GAIN_Y;
        v[cpcr_pkg::CFG_FALL_DAMPING]   = cpcr_pkg::RST_FALL_DAMPING;
        v[cpcr_pkg::CFG_FLOOR_FRICTION] = cpcr_pkg::RST_FLOOR_FRICTION;
        v[cpcr_pkg::CFG_FLOOR_MARGIN]   = cpcr_pkg::RST_FLOOR_MARGIN;
      end
      write_regs(v);
      for (int n = 0; n < 215; n++) begin
        if (n % 50 == 0) burst = $urandom_range(0, 2) == 0;
        if (ph == 2 && n == 100) begin
          // let the pipeline empty completely before resuming
          in_tvalid <= 1'b0;
          wait (sb.pending_q.size() == 0);
          @(posedge clk);
        end
        send_pair(rand_pair($urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1)));
      end
      burst = 0;
      drain();
    end

    if (sb.n_err == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3200000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
